FILE: rtl/core/taint_shadow_range_engine_defines.svh
`ifndef TAINT_SHADOW_RANGE_ENGINE_DEFINES_SVH
`define TAINT_SHADOW_RANGE_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while arst_n is low.
`define TSRE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TSRE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/tsre_pkg.sv
`default_nettype none

package tsre_pkg;

	localparam int ADDR_BITS_DEF = 16;
	localparam int FIELD_W       = 16;

	typedef enum logic [1:0] {
		OP_MARK  = 2'd0,
		OP_PROP  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_CHECK = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_WIPE,
		S_IDLE,
		S_WALK,
		S_DRAIN,
		S_CHK_RD,
		S_CHK_WAIT,
		S_DONE
	} state_t;

	// Shadow store port controls, addresses travel separately
	typedef struct packed {
		logic wr_en;
		logic wr_data;
		logic rd_en;
	} ram_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/tsre_if.sv
`default_nettype none

interface tsre_in_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     opcode;
	logic [tsre_pkg::FIELD_W-1:0]   first_addr;
	logic [tsre_pkg::FIELD_W-1:0]   source_addr;
	logic [tsre_pkg::FIELD_W-1:0]   byte_count;

	modport source (output valid, opcode, first_addr, source_addr, byte_count, input ready);
	modport sink   (input valid, opcode, first_addr, source_addr, byte_count, output ready);
endinterface

interface tsre_out_if;
	logic valid;
	logic ready;
	logic tainted_hit;
	logic op_done;

	modport source (output valid, tainted_hit, op_done, input ready);
	modport sink   (input valid, tainted_hit, op_done, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tsre_ram.sv
`default_nettype none

module tsre_ram #(
	parameter int WIDTH      = 1,
	parameter int DEPTH_LOG2 = tsre_pkg::ADDR_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [DEPTH_LOG2-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]      wr_data,
	input  wire logic                  rd_en,
	input  wire logic [DEPTH_LOG2-1:0] rd_addr,
	output      logic [WIDTH-1:0]      rd_data
);

	logic [WIDTH-1:0] mem_q [(64'd1 << DEPTH_LOG2)];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/tsre_seq.sv
`default_nettype none

module tsre_seq #(
	parameter int ADDR_BITS = tsre_pkg::ADDR_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [1:0]                   opcode,
	input  wire logic [tsre_pkg::FIELD_W-1:0] first_addr,
	input  wire logic [tsre_pkg::FIELD_W-1:0] source_addr,
	input  wire logic [tsre_pkg::FIELD_W-1:0] byte_count,
	output      logic                         idle,
	input  wire logic                         rd_bit,
	output      tsre_pkg::ram_ctl_t           ctl,
	output      logic [ADDR_BITS-1:0]         wr_addr,
	output      logic [ADDR_BITS-1:0]         rd_addr,
	output      logic                         res_valid,
	output      logic                         res_hit,
	input  wire logic                         res_take
);

	tsre_pkg::state_t state_q, state_d;
	tsre_pkg::op_t    op_q;
	tsre_pkg::op_t    op_in;
	logic [ADDR_BITS-1:0]         addr_q;
	logic [ADDR_BITS-1:0]         src_q;
	logic [tsre_pkg::FIELD_W-1:0] cnt_q;
	logic                         hit_q;
	logic                         pend_s1;   // propagate read in flight, write due this cycle

	assign op_in = tsre_pkg::op_t'(opcode);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsre_pkg::S_WIPE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ctl         = '0;
		wr_addr     = addr_q;
		rd_addr     = src_q;
		idle        = 1'b0;
		res_valid   = 1'b0;
		unique case (state_q)
			tsre_pkg::S_WIPE: begin
				ctl.wr_en = 1'b1;
				if (addr_q == '1) begin
					state_d = tsre_pkg::S_IDLE;
				end
			end
			tsre_pkg::S_IDLE: begin
				idle = 1'b1;
				if (start) begin
					priority if (op_in == tsre_pkg::OP_CHECK) begin
						state_d = tsre_pkg::S_CHK_RD;
					end else if (byte_count == '0) begin
						state_d = tsre_pkg::S_DONE;
					end else begin
						state_d = tsre_pkg::S_WALK;
					end
				end
			end
			tsre_pkg::S_WALK: begin
				if (op_q == tsre_pkg::OP_PROP) begin
					ctl.rd_en = 1'b1;
				end else begin
					ctl.wr_en   = 1'b1;
					ctl.wr_data = (op_q == tsre_pkg::OP_MARK);
				end
				if (cnt_q == tsre_pkg::FIELD_W'(1)) begin
					state_d = (op_q == tsre_pkg::OP_PROP) ? tsre_pkg::S_DRAIN
						: tsre_pkg::S_DONE;
				end
			end
			tsre_pkg::S_DRAIN: begin
				state_d = tsre_pkg::S_DONE;
			end
			tsre_pkg::S_CHK_RD: begin
				ctl.rd_en = 1'b1;
				rd_addr   = addr_q;
				state_d   = tsre_pkg::S_CHK_WAIT;
			end
			tsre_pkg::S_CHK_WAIT: begin
				state_d = tsre_pkg::S_DONE;
			end
			tsre_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = tsre_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tsre_pkg::S_IDLE;
			end
		endcase
		// propagate write half: taint the destination only when the source bit is set
		if (pend_s1) begin
			ctl.wr_en   = rd_bit;
			ctl.wr_data = 1'b1;
		end
	end

	assign res_hit = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			src_q   <= '0;
			cnt_q   <= '0;
			op_q    <= tsre_pkg::OP_MARK;
			hit_q   <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= (state_q == tsre_pkg::S_WALK) && (op_q == tsre_pkg::OP_PROP);
			if (idle && start) begin
				addr_q <= ADDR_BITS'(first_addr);
				src_q  <= ADDR_BITS'(source_addr);
				cnt_q  <= byte_count;
				op_q   <= op_in;
				hit_q  <= 1'b0;
			end else begin
				if ((state_q == tsre_pkg::S_WIPE) || pend_s1 ||
						((state_q == tsre_pkg::S_WALK) && (op_q != tsre_pkg::OP_PROP))) begin
					addr_q <= addr_q + ADDR_BITS'(1);
				end
				if ((state_q == tsre_pkg::S_WALK) && (op_q == tsre_pkg::OP_PROP)) begin
					src_q <= src_q + ADDR_BITS'(1);
				end
				if (state_q == tsre_pkg::S_WALK) begin
					cnt_q <= cnt_q - tsre_pkg::FIELD_W'(1);
				end
				if (state_q == tsre_pkg::S_CHK_WAIT) begin
					hit_q <= rd_bit;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/taint_shadow_range_engine.sv
`default_nettype none

// Channel  Dir  Payload                                         Transfer
// req      in   opcode, first_addr, source_addr, byte_count      valid & ready
// rsp      out  tainted_hit, op_done                             valid & ready
//
// After reset the shadow store is wiped, one address a cycle, with req.ready low.
// Mark and clear walk the range, then finish; propagate drains after its walk;
// check reads, waits, then finishes; with a zero count the others finish at once.
// The walk goes one byte a cycle over the single shadow store port pair.
// A finished result sits in the rsp register; req is taken again while it waits.
// The walker holds in its last state only while rsp is full and stalled.

`include "taint_shadow_range_engine_defines.svh"

module taint_shadow_range_engine #(
	parameter int ADDR_BITS = tsre_pkg::ADDR_BITS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	tsre_in_if.sink     req,
	tsre_out_if.source  rsp
);

	tsre_pkg::ram_ctl_t     ram_ctl;
	logic [ADDR_BITS-1:0]   wr_addr;
	logic [ADDR_BITS-1:0]   rd_addr;
	logic                   ram_q;
	logic                   rd_bit;
	logic                   fwd_q;
	logic                   fwd_bit_q;
	logic                   seq_idle;
	logic                   res_valid;
	logic                   res_hit;
	logic                   res_take;
	logic                   out_valid_q;
	logic                   out_hit_q;

	tsre_seq #(
		.ADDR_BITS (ADDR_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (req.valid),
		.opcode      (req.opcode),
		.first_addr  (req.first_addr),
		.source_addr (req.source_addr),
		.byte_count  (req.byte_count),
		.idle        (seq_idle),
		.rd_bit      (rd_bit),
		.ctl         (ram_ctl),
		.wr_addr     (wr_addr),
		.rd_addr     (rd_addr),
		.res_valid   (res_valid),
		.res_hit     (res_hit),
		.res_take    (res_take)
	);

	tsre_ram #(
		.WIDTH      (1),
		.DEPTH_LOG2 (ADDR_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_ctl.wr_en),
		.wr_addr (wr_addr),
		.wr_data (ram_ctl.wr_data),
		.rd_en   (ram_ctl.rd_en),
		.rd_addr (rd_addr),
		.rd_data (ram_q)
	);

	// overlapping propagate: a bit written in the same cycle it is read is forwarded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q     <= 1'b0;
			fwd_bit_q <= 1'b0;
		end else begin
			fwd_q     <= ram_ctl.wr_en && ram_ctl.rd_en && (wr_addr == rd_addr);
			fwd_bit_q <= ram_ctl.wr_data;
		end
	end

	assign rd_bit = fwd_q ? fwd_bit_q : ram_q;

	assign req.ready = seq_idle;
	assign res_take  = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
			out_hit_q   <= res_hit;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.tainted_hit = out_hit_q;
	assign rsp.op_done     = 1'b1;

	`TSRE_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready,
		"request taken while previous operation in progress")
	`TSRE_ASSERT_NOW(a_no_write_when_idle, req.ready, !ram_ctl.wr_en,
		"shadow store written while engine idle")
	`TSRE_ASSERT_NOW(a_no_result_when_idle, req.ready, !res_valid,
		"result offered while engine idle")

endmodule

`default_nettype wire

FILE: verif/taint_shadow_range_engine_tb.sv
`timescale 1ns / 100ps

module taint_shadow_range_engine_tb;

	typedef struct packed {
		tsre_pkg::op_t                opcode;
		logic [tsre_pkg::FIELD_W-1:0] first_addr;
		logic [tsre_pkg::FIELD_W-1:0] source_addr;
		logic [tsre_pkg::FIELD_W-1:0] byte_count;
	} shadow_op_t;

	typedef struct packed {
		logic tainted_hit;
		logic op_done;
	} op_result_t;

	logic clk = 1'b0;
	logic arst_n;

	tsre_in_if  req_ch ();
	tsre_out_if rsp_ch ();

	taint_shadow_range_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	shadow_op_t pending_ops [$];
	op_result_t verdict_q [$];
	bit         taint_map [0:(1 << tsre_pkg::FIELD_W) - 1];

	int         ops_queued    = 0;
	int         ops_accepted  = 0;
	int         err_cnt       = 0;
	int         idle_pct      = 36;
	int         rsp_hold_req  = 0;
	int         rsp_hold_seen = 0;
	int         rsp_hold_left = 0;
	logic       req_taken     = 1'b0;
	shadow_op_t next_op;
	op_result_t got;
	op_result_t want;

	// Shadow model: applies one operation to taint_map and returns its result
	function automatic op_result_t shadow_apply(shadow_op_t op);
		op_result_t                   res;
		logic [tsre_pkg::FIELD_W-1:0] dst;
		logic [tsre_pkg::FIELD_W-1:0] src;
		int                           k;
		res.tainted_hit = 1'b0;
		res.op_done     = 1'b1;
		for (k = 0; op.opcode != tsre_pkg::OP_CHECK && k < int'(op.byte_count); k++) begin
			dst = op.first_addr + k[tsre_pkg::FIELD_W-1:0];
			src = op.source_addr + k[tsre_pkg::FIELD_W-1:0];
			case (op.opcode)
				tsre_pkg::OP_MARK:  taint_map[dst] = 1'b1;
				tsre_pkg::OP_PROP:  if (taint_map[src]) taint_map[dst] = 1'b1;
				default:            taint_map[dst] = 1'b0;
			endcase
		end
		if (op.opcode == tsre_pkg::OP_CHECK)
			res.tainted_hit = taint_map[op.first_addr];
		return res;
	endfunction

	task automatic enqueue(tsre_pkg::op_t opc, int fa, int sa, int cnt);
		shadow_op_t op;
		op.opcode      = opc;
		op.first_addr  = fa[tsre_pkg::FIELD_W-1:0];
		op.source_addr = sa[tsre_pkg::FIELD_W-1:0];
		op.byte_count  = cnt[tsre_pkg::FIELD_W-1:0];
		pending_ops.insert(pending_ops.size(), op);
		ops_queued++;
	endtask

	task automatic enqueue_random(int n);
		int i;
		int sel;
		int fa;
		int sa;
		int cnt;
		tsre_pkg::op_t opc;
		for (i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 25)      opc = tsre_pkg::OP_MARK;
			else if (sel < 45) opc = tsre_pkg::OP_PROP;
			else if (sel < 65) opc = tsre_pkg::OP_CLEAR;
			else               opc = tsre_pkg::OP_CHECK;
			// mostly a small window straddling the top of the address space
			if ($urandom_range(99) < 80) begin
				fa = (16'hFFC0 + $urandom_range(0, 191)) & 16'hFFFF;
				sa = (16'hFFC0 + $urandom_range(0, 191)) & 16'hFFFF;
			end else begin
				fa = $urandom_range(16'hFFFF);
				sa = $urandom_range(16'hFFFF);
			end
			sel = $urandom_range(99);
			if (sel < 70)      cnt = $urandom_range(0, 48);
			else if (sel < 95) cnt = $urandom_range(49, 300);
			else               cnt = $urandom_range(301, 2000);
			enqueue(opc, fa, sa, cnt);
		end
	endtask

	task automatic wait_quiet();
		while (ops_accepted != ops_queued || verdict_q.size() != 0)
			@(posedge clk);
	endtask

	// Request side: a new item is offered once the previous one has made its transfer
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_ch.valid || req_taken) begin
				if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
					next_op = pending_ops.pop_front();
					req_ch.valid       <= 1'b1;
					req_ch.opcode      <= next_op.opcode;
					req_ch.first_addr  <= next_op.first_addr;
					req_ch.source_addr <= next_op.source_addr;
					req_ch.byte_count  <= next_op.byte_count;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		req_taken <= req_ch.valid && req_ch.ready;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			verdict_q.insert(verdict_q.size(),
				shadow_apply({tsre_pkg::op_t'(req_ch.opcode), req_ch.first_addr,
				req_ch.source_addr, req_ch.byte_count}));
			ops_accepted++;
		end
	end

	// Response side: random back-pressure plus a long hold-off when one is requested
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_hold_req != rsp_hold_seen) begin
				rsp_hold_seen = rsp_hold_req;
				rsp_hold_left = 400;
			end
			if (rsp_hold_left > 0) begin
				rsp_hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.tainted_hit = rsp_ch.tainted_hit;
			got.op_done     = rsp_ch.op_done;
			if (verdict_q.size() == 0) begin
				$display("%0t: result expected none actual hit=%b done=%b", $time,
					got.tainted_hit, got.op_done);
				err_cnt++;
			end else begin
				want = verdict_q.pop_front();
				if (got.tainted_hit !== want.tainted_hit) begin
					$display("%0t: tainted_hit expected %b actual %b", $time,
						want.tainted_hit, got.tainted_hit);
					err_cnt++;
				end
				if (got.op_done !== want.op_done) begin
					$display("%0t: op_done expected %b actual %b", $time,
						want.op_done, got.op_done);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		#(40_000_000);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.opcode      = tsre_pkg::OP_MARK;
		req_ch.first_addr  = '0;
		req_ch.source_addr = '0;
		req_ch.byte_count  = '0;
		rsp_ch.ready       = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wrap at the top of the window
		enqueue(tsre_pkg::OP_CHECK, 16'h0000, 16'hFFFF, 16'hFFFF);
		enqueue(tsre_pkg::OP_MARK,  16'hFFFE, 16'h0000, 4);
		enqueue(tsre_pkg::OP_CHECK, 16'hFFFF, 16'h0000, 0);
		enqueue(tsre_pkg::OP_CHECK, 16'h0001, 16'h0000, 0);
		enqueue(tsre_pkg::OP_CHECK, 16'h0002, 16'h0000, 0);
		// zero counts do nothing
		enqueue(tsre_pkg::OP_MARK,  16'h1234, 16'h0000, 0);
		enqueue(tsre_pkg::OP_CHECK, 16'h1234, 16'h0000, 0);
		enqueue(tsre_pkg::OP_PROP,  16'h1234, 16'hFFFE, 0);
		// propagate from a wrapping source
		enqueue(tsre_pkg::OP_PROP,  16'h0100, 16'hFFFE, 4);
		enqueue(tsre_pkg::OP_CHECK, 16'h0103, 16'h0000, 0);
		// overlapping propagate chains forward
		enqueue(tsre_pkg::OP_MARK,  16'h0200, 16'h0000, 1);
		enqueue(tsre_pkg::OP_PROP,  16'h0201, 16'h0200, 8);
		enqueue(tsre_pkg::OP_CHECK, 16'h0208, 16'h0000, 0);
		// clear across the wrap, and over untainted bytes
		enqueue(tsre_pkg::OP_CLEAR, 16'hFFFF, 16'h0000, 3);
		enqueue(tsre_pkg::OP_CHECK, 16'h0000, 16'h0000, 0);
		enqueue(tsre_pkg::OP_CHECK, 16'hFFFE, 16'h0000, 0);
		enqueue(tsre_pkg::OP_CLEAR, 16'h0300, 16'h0000, 5);
		enqueue(tsre_pkg::OP_CHECK, 16'h0302, 16'h0000, 0);
		// full-length ranges
		enqueue(tsre_pkg::OP_MARK,  16'h8000, 16'hFFFF, 16'hFFFF);
		enqueue(tsre_pkg::OP_CHECK, 16'h7FFF, 16'h0000, 0);
		enqueue(tsre_pkg::OP_CLEAR, 16'h0000, 16'h0000, 16'hFFFF);
		enqueue(tsre_pkg::OP_CHECK, 16'hFFFF, 16'h0000, 0);
		enqueue(tsre_pkg::OP_PROP,  16'hFFFF, 16'hFFFE, 16'hFFFF);
		enqueue(tsre_pkg::OP_CHECK, 16'h4321, 16'h0000, 0);
		enqueue(tsre_pkg::OP_CLEAR, 16'h0001, 16'h0000, 16'hFFFF);

		enqueue_random(200);
		wait_quiet();

		// hold the response side off while requests keep coming
		rsp_hold_req++;
		enqueue_random(40);
		wait_quiet();

		idle_pct = 0;
		enqueue_random(150);
		wait_quiet();

		idle_pct = 36;
		enqueue_random(110);
		wait_quiet();
		repeat (50) @(posedge clk);

		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: taint_shadow_range_engine.f
+incdir+rtl/core
rtl/core/tsre_pkg.sv
rtl/core/tsre_if.sv
rtl/core/tsre_ram.sv
rtl/core/tsre_seq.sv
rtl/core/taint_shadow_range_engine.sv
verif/taint_shadow_range_engine_tb.sv
